// ----- rtl/core/brf_pkg.sv -----
// brf_pkg: types and constants shared by the byte ring fifo modules
// no dependencies
package brf_pkg;

  localparam int unsigned DEPTH_DEF = 256;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned RING_RST  = 256;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_DISCARD = 2'd2,
    OP_CLEAR   = 2'd3
  } fifo_op_e;

  typedef struct packed {
    fifo_op_e            op;
    logic [DATA_W-1:0]   write_data;
    logic [CNT_W-1:0]    discard_count;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic                done_res;
    logic [CNT_W-1:0]    available;
    logic [CNT_W-1:0]    room_left;
  } out_item_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic load;    // capture the item, memory read starts at this edge
    logic exec;    // apply the operation and register the result
    logic cfg_we;  // size register write, empties the fifo
  } ctrl_cmd_t;

endpackage

// ----- rtl/core/brf_ctrl.sv -----
// brf_ctrl: two-state sequencer for the byte ring fifo
// depends on brf_pkg
module brf_ctrl import brf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      cfg_valid_i,
  output logic      busy,
  output logic      cfg_ready_o,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    busy        = 1'b0;
    cfg_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cfg_ready_o  = 1'b1;
        cmd_o.load   = start;
        cmd_o.cfg_we = cfg_valid_i;
      end
      ST_EXEC: begin
        busy       = 1'b1;
        cmd_o.exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/brf_dp.sv -----
// brf_dp: byte store, pointers, fill count and result register
// depends on brf_pkg; driven by brf_ctrl commands
module brf_dp import brf_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  input  in_item_t          item_i,
  input  logic [CNT_W-1:0]  cfg_data_i,
  output out_item_t         result_o,
  output logic              result_valid_o
);

  localparam int unsigned PTR_W    = $clog2(DEPTH);
  localparam int unsigned AW       = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
  localparam int unsigned SIZE_RST = (RING_RST > DEPTH) ? DEPTH : RING_RST;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_q;

  logic [CNT_W-1:0]  size_q, size_d;
  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic [PTR_W-1:0]  rptr_q, rptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  in_item_t          item_q;
  out_item_t         res_q, res_d;
  logic              res_valid_q;

  logic              full, empty, mem_we;
  logic [CNT_W-1:0]  clip, rinc;
  logic [AW-1:0]     rsum, wsum;

  // saturate the requested size into 1..DEPTH
  always_comb begin
    if (cfg_data_i == '0) begin
      size_d = CNT_W'(1);
    end else if (32'(cfg_data_i) > DEPTH) begin
      size_d = CNT_W'(DEPTH);
    end else begin
      size_d = cfg_data_i;
    end
  end

  always_comb begin
    full  = (count_q >= size_q);
    empty = (count_q == '0);
    clip  = (item_q.discard_count > count_q) ? count_q : item_q.discard_count;
    rinc  = '0;
    mem_we = 1'b0;
    res_d = '0;
    case (item_q.op)
      OP_WRITE:   mem_we = cmd_i.exec && !full;
      OP_READ:    rinc   = empty ? '0 : CNT_W'(1);
      OP_DISCARD: rinc   = clip;
      default:    rinc   = '0;
    endcase

    // pointers stay below size, so one subtract covers the wrap
    rsum = AW'(rptr_q) + AW'(rinc);
    if (rsum >= AW'(size_q)) rsum = rsum - AW'(size_q);
    wsum = AW'(wptr_q) + AW'(1);
    if (wsum >= AW'(size_q)) wsum = wsum - AW'(size_q);

    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    case (item_q.op)
      OP_WRITE: begin
        if (!full) begin
          wptr_d         = wsum[PTR_W-1:0];
          count_d        = count_q + CNT_W'(1);
          res_d.done_res = 1'b1;
        end
      end
      OP_READ: begin
        if (!empty) begin
          rptr_d          = rsum[PTR_W-1:0];
          count_d         = count_q - CNT_W'(1);
          res_d.done_res  = 1'b1;
          res_d.read_data = rd_q;
        end
      end
      OP_DISCARD: begin
        rptr_d         = rsum[PTR_W-1:0];
        count_d        = count_q - clip;
        res_d.done_res = 1'b1;
      end
      OP_CLEAR: begin
        wptr_d         = '0;
        rptr_d         = '0;
        count_d        = '0;
        res_d.done_res = 1'b1;
      end
      default: begin
        res_d.done_res = 1'b0;
      end
    endcase
    res_d.available = count_d;
    res_d.room_left = size_q - count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= CNT_W'(SIZE_RST);
      wptr_q      <= '0;
      rptr_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.exec;
      if (cmd_i.cfg_we) begin
        size_q  <= size_d;
        wptr_q  <= '0;
        rptr_q  <= '0;
        count_q <= '0;
      end else if (cmd_i.exec) begin
        wptr_q  <= wptr_d;
        rptr_q  <= rptr_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (cmd_i.exec) res_q  <= res_d;
  end

  // registered read at the head pointer, valid in the cycle after the transfer
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wptr_q] <= item_q.write_data;
    rd_q <= mem_q[rptr_q];
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

endmodule

// ----- rtl/core/byte_ring_fifo_with_discard.sv -----
// byte_ring_fifo_with_discard: top level of the circular byte fifo
// depends on brf_pkg, brf_ctrl, brf_dp
//
// Usage:
//   Command channel: drive cmd_i and raise start; the command transfers on a
//   rising edge where start is high and busy is low. Ops are write byte,
//   read byte, discard up to discard_count oldest bytes, and clear.
//   Result channel: result_o is valid for exactly one cycle while
//   result_valid_o is high, registered after the execute state. The
//   receiver cannot stall; it must take the result in that cycle.
//   No command is taken while busy. busy is high for the cycle in
//   which the store is read through its registered port and the pointers
//   are updated; a new command may transfer in the cycle the result shows.
//   Config channel: cfg_data_i sets the ring size (saturated to 1..DEPTH)
//   on a cycle where cfg_valid_i and cfg_ready_o are high, and empties the
//   fifo. Write it only while no command is in flight.
//   Reset: pointers and fill count go to zero, ring size to 256 (or DEPTH
//   if smaller). Store contents are not cleared; nothing reads them before
//   they are written.
module byte_ring_fifo_with_discard import brf_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  in_item_t         cmd_i,
  output out_item_t        result_o,
  output logic             result_valid_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i
);

  ctrl_cmd_t ctrl_cmd;

  brf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cfg_valid_i (cfg_valid_i),
    .busy        (busy),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (ctrl_cmd)
  );

  brf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .item_i         (cmd_i),
    .cfg_data_i     (cfg_data_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("command transfer did not enter execute");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> result_valid_o && !busy)
    else $error("execute cycle not followed by a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without a command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.done_res |-> result_o.read_data == '0)
    else $error("read data nonzero on a failed operation");

endmodule
